### hdl/aes_pkg.sv
// Package: shared types, constants and round functions for the AES encrypt core
`timescale 1ns / 1ps
package aes_pkg;
    localparam int KEY_WORDS = 60;
    localparam int KEY_AW    = 6;
    localparam int KEY_RW    = 4;
    localparam logic [KEY_AW-1:0] KEY_LAST = 6'(KEY_WORDS - 1);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ENCRYPT = 1'b1;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_RW-1:0] rnd;
    } t_key_req;

    typedef logic [7:0] t_sbox [256];

    localparam t_sbox SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // state as 128 bits, byte 0 at the top, column-major
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(c*4 + r) -: 8] = SBOX[s[127 - 8*(((c + r) % 4)*4 + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction
endpackage

### hdl/aes_if.sv
// Interfaces: input and output item channels
`timescale 1ns / 1ps
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [5:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, func, key_index, key_word, block_hi, block_lo, input ready);
    modport sink (input valid, func, key_index, key_word, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
    modport source (output valid, cipher_hi, cipher_lo, input ready);
    modport sink (input valid, cipher_hi, cipher_lo, output ready);
endinterface

### hdl/aes_block_encrypt_core.sv
// Top level: AES block encryption over a loaded, expanded round-key store
`timescale 1ns / 1ps
// Usage:
//  i_in carries items: func load writes key_word into entry key_index of
//  the round-key store (no result); func encrypt brings a block.
//  i_key_size_we/i_key_size_wd set the key size (0:10, 1:12, else 14
//  rounds); the user must write it only while idle, the block itself does
//  not enforce this. o_out delivers one ciphertext per encrypt item.
//  Each round reads its 128-bit round key from four word RAMs with a
//  registered read; one round is done per cycle. One item is worked on at
//  a time. Loads are accepted back to back; after an encrypt item the next
//  item is accepted only once its result is in the output register.
//  The result sits in an output register; a new item is accepted while it
//  waits, but its result waits for the receiver before it is written.
//  Reset clears control state and sets key size to 128-bit; store contents
//  are undefined until loaded. A stalled receiver holds the result stable.
module aes_block_encrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_key_size_we,
    input  logic [1:0]  i_key_size_wd,
    aes_in_if.sink      i_in,
    aes_out_if.source   o_out
);
    aes_pkg::t_state   r_state, n_state;
    aes_pkg::t_key_req w_req;
    logic [1:0]        r_ks;
    logic [3:0]        r_rnd, n_rnd, w_nr;
    logic [127:0]      r_s, w_key, w_ss, w_mix;
    logic [127:0]      r_out;
    logic              r_ov;
    logic              w_acc, w_done;

    assign w_nr = (r_ks == aes_pkg::KS_128) ? 4'd10 : (r_ks == aes_pkg::KS_192) ? 4'd12 : 4'd14;
    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == aes_pkg::ST_IDLE);
    assign w_done = (r_state == aes_pkg::ST_OUT) && (!r_ov || o_out.ready);

    assign w_req.rnd   = n_rnd;

    aes_keystore u_keys (
        .i_clk  (i_clk),
        .i_we   (w_acc && i_in.func == aes_pkg::FUNC_LOAD),
        .i_widx (i_in.key_index),
        .i_wdata(i_in.key_word),
        .i_req  (w_req),
        .o_key  (w_key)
    );

    assign w_ss  = aes_pkg::sub_shift(r_s);
    assign w_mix = aes_pkg::mix_cols(w_ss);

    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::ST_IDLE:  if (w_acc && i_in.func == aes_pkg::FUNC_ENCRYPT) begin
                n_state = aes_pkg::ST_FETCH;
            end
            aes_pkg::ST_FETCH: n_state = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND: if (r_rnd == w_nr) begin
                n_state = aes_pkg::ST_OUT;
            end
            aes_pkg::ST_OUT:   if (w_done) begin
                n_state = aes_pkg::ST_IDLE;
            end
            default:           n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            aes_pkg::ST_FETCH: n_rnd = 4'd1;
            aes_pkg::ST_ROUND: n_rnd = r_rnd + 4'd1;
            default:           n_rnd = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::ST_IDLE;
            r_ks    <= aes_pkg::KS_128;
            r_rnd   <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            if (i_key_size_we) begin
                r_ks <= i_key_size_wd;
            end
            if (w_done) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s <= {i_in.block_hi, i_in.block_lo};
        end else if (r_state == aes_pkg::ST_FETCH) begin
            r_s <= r_s ^ w_key;
        end else if (r_state == aes_pkg::ST_ROUND) begin
            r_s <= ((r_rnd == w_nr) ? w_ss : w_mix) ^ w_key;
        end
        if (w_done) begin
            r_out <= r_s;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.cipher_hi = r_out[127:64];
    assign o_out.cipher_lo = r_out[63:0];

    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_out.valid) else $error("result not raised");
    a_rnd_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == aes_pkg::ST_ROUND |-> r_rnd <= w_nr) else $error("round overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_out)) else $error("result lost");
endmodule

### hdl/aes_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/aes_keystore.sv
// Round-key store: four word banks, one 128-bit round key read per cycle
`timescale 1ns / 1ps
module aes_keystore (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [aes_pkg::KEY_AW-1:0]    i_widx,
    input  logic [31:0]                   i_wdata,
    input  aes_pkg::t_key_req             i_req,
    output logic [127:0]                  o_key
);
    logic [127:0] w_rd;
    logic         r_zero;

    // banks hold word c of each round key; depth 16 rounds
    for (genvar c = 0; c < 4; c++) begin : g_bank
        aes_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_we && i_widx[1:0] == 2'(c) && i_widx <= aes_pkg::KEY_LAST),
            .i_waddr(i_widx[aes_pkg::KEY_AW-1:2]),
            .i_wdata(i_wdata),
            .i_raddr(i_req.rnd),
            .o_rdata(w_rd[127 - 32*c -: 32])
        );
    end

    // round words beyond the store read as zero
    always_ff @(posedge i_clk) begin
        r_zero <= ({i_req.rnd, 2'b00} > aes_pkg::KEY_LAST);
    end

    assign o_key = r_zero ? 128'd0 : w_rd;
endmodule
